/* src/mbox_message_counter_top_assert.svh */
// Assertion macros for the mailbox message counter.
// Each macro takes a label, a clock, an active-low reset, a trigger and a consequence.
`ifndef MBOX_MESSAGE_COUNTER_TOP_ASSERT_SVH
`define MBOX_MESSAGE_COUNTER_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the trigger
`define MMC_ASSERT_SAME(lbl, clock, rstn, trig, cons) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (trig) |-> (cons)) \
        else $error("mmc assertion failed: same-cycle check");

// Consequence must hold in the cycle after the trigger
`define MMC_ASSERT_NEXT(lbl, clock, rstn, trig, cons) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("mmc assertion failed: next-cycle check");

`endif

/* src/mmc_pkg.sv */
package mmc_pkg;

    // Counter width and result field width
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int EXT_W       = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    // Characters of interest
    localparam logic [7:0] CH_F     = 8'h46;  // 'F'
    localparam logic [7:0] CH_S     = 8'h53;  // 'S'
    localparam logic [7:0] CH_R     = 8'h52;  // 'R'
    localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
    localparam logic [7:0] CH_LF    = 8'h0a;  // newline
    localparam logic [7:0] CH_LO_R  = 8'h72;  // 'r'
    localparam logic [7:0] CH_LO_O  = 8'h6f;  // 'o'
    localparam logic [7:0] CH_LO_M  = 8'h6d;  // 'm'
    localparam logic [7:0] CH_LO_T  = 8'h74;  // 't'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_U  = 8'h75;  // 'u'
    localparam logic [7:0] CH_LO_S  = 8'h73;  // 's'
    localparam logic [7:0] CH_SP    = 8'h20;  // ' '

    // Match progress codes
    localparam logic [3:0] PROG_IDLE      = 4'd0;
    localparam logic [3:0] PROG_F         = 4'd1;
    localparam logic [3:0] PROG_FR        = 4'd2;
    localparam logic [3:0] PROG_FRO       = 4'd3;
    localparam logic [3:0] PROG_FROM      = 4'd4;
    localparam logic [3:0] PROG_S         = 4'd5;
    localparam logic [3:0] PROG_ST        = 4'd6;
    localparam logic [3:0] PROG_STA       = 4'd7;
    localparam logic [3:0] PROG_STAT      = 4'd8;
    localparam logic [3:0] PROG_STATU     = 4'd9;
    localparam logic [3:0] PROG_STATUS    = 4'd10;
    localparam logic [3:0] PROG_STATUS_C  = 4'd11;
    localparam logic [3:0] PROG_STATUS_SP = 4'd12;

    // One input transaction as held in the input register
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } byte_item_t;

    // Counter values handed from the scanner to the result register
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] msgs;
        logic [COUNT_WIDTH-1:0] reads;
    } count_pair_t;

    // Byte expected next for a given partial match
    function automatic logic [7:0] expected_byte(input logic [3:0] prog);
        logic [7:0] ch;
        case (prog)
            PROG_F:         ch = CH_LO_R;
            PROG_FR:        ch = CH_LO_O;
            PROG_FRO:       ch = CH_LO_M;
            PROG_FROM:      ch = CH_SP;
            PROG_S:         ch = CH_LO_T;
            PROG_ST:        ch = CH_LO_A;
            PROG_STA:       ch = CH_LO_T;
            PROG_STAT:      ch = CH_LO_U;
            PROG_STATU:     ch = CH_LO_S;
            PROG_STATUS:    ch = CH_COLON;
            PROG_STATUS_C:  ch = CH_SP;
            PROG_STATUS_SP: ch = CH_R;
            default:        ch = CH_F;
        endcase
        return ch;
    endfunction

    // Saturating increment
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Clamp a count to the result field width
    function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
    endfunction

endpackage

/* src/mbox_message_counter_top.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | data_byte, end_of_file
// out     | output    | out_valid/out_stall | message_count, unread_count
//
// One byte per cycle is accepted while in_stall is low. The end-of-file byte
// passes the input register, then the result register, before out_valid rises.
// rst_n clears all scan state and both valid flags asynchronously.
// in_stall rises only when an end-of-file byte waits behind a result that
// is stalled at the output; ordinary bytes keep flowing while a result waits.
`include "mbox_message_counter_top_assert.svh"

module mbox_message_counter_top
    import mmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             end_of_file,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OUT_W-1:0] message_count,
    output logic [OUT_W-1:0] unread_count
);

    logic        out_free;
    logic        proc_en;
    byte_item_t  item;
    count_pair_t counts;

    // Input register
    mmc_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .in_stall    (in_stall),
        .out_free    (out_free),
        .proc_en     (proc_en),
        .item        (item)
    );

    // Line and pattern scanner with counters
    mmc_scanner u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .proc_en (proc_en),
        .item    (item),
        .counts  (counts)
    );

    // Result register
    mmc_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (proc_en && item.eof),
        .counts        (counts),
        .out_stall     (out_stall),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .message_count (message_count),
        .unread_count  (unread_count)
    );

    // Checks
    `MMC_ASSERT_SAME(a_unread_le_msgs, clk, rst_n, out_valid, unread_count <= message_count)
    `MMC_ASSERT_NEXT(a_eof_gives_result, clk, rst_n, proc_en && item.eof, out_valid)
    `MMC_ASSERT_SAME(a_eof_waits, clk, rst_n, proc_en && item.eof && out_valid, !out_stall)
    `MMC_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(message_count) && $stable(unread_count))

endmodule

/* src/mmc_in_stage.sv */
module mmc_in_stage
    import mmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output logic       in_stall,
    input  logic       out_free,
    output logic       proc_en,
    output byte_item_t item
);

    logic       vld_reg;
    logic       vld_next;
    byte_item_t item_reg;

    // An end-of-file byte needs room in the result register
    assign proc_en  = vld_reg && (!item_reg.eof || out_free);
    assign in_stall = vld_reg && !proc_en;
    assign item     = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && !in_stall)
        begin
            vld_next = 1'b1;
        end
        else if (proc_en)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.data <= data_byte;
            item_reg.eof  <= end_of_file;
        end
    end

endmodule

/* src/mmc_scanner.sv */
module mmc_scanner
    import mmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        proc_en,
    input  byte_item_t  item,
    output count_pair_t counts
);

    logic                   line_start_reg, line_start_next;
    logic                   in_header_reg,  in_header_next;
    logic                   read_seen_reg,  read_seen_next;
    logic [3:0]             prog_reg,       prog_next;
    logic [COUNT_WIDTH-1:0] msgs_reg,       msgs_next;
    logic [COUNT_WIDTH-1:0] reads_reg,      reads_next;
    logic                   hit;
    logic                   is_lf;

    assign hit   = (item.data == expected_byte(prog_reg));
    assign is_lf = (item.data == CH_LF);

    // Per-byte pattern tracking
    always_comb
    begin
        line_start_next = line_start_reg;
        in_header_next  = in_header_reg;
        read_seen_next  = read_seen_reg;
        prog_next       = PROG_IDLE;
        msgs_next       = msgs_reg;
        reads_next      = reads_reg;

        if (prog_reg >= PROG_F && prog_reg <= PROG_STATUS_SP)
        begin
            if (!hit)
            begin
                line_start_next = is_lf;
            end
            else if (prog_reg == PROG_FROM)
            begin
                msgs_next       = sat_inc(msgs_reg);
                in_header_next  = 1'b1;
                read_seen_next  = 1'b0;
                line_start_next = 1'b0;
            end
            else if (prog_reg == PROG_STATUS_SP)
            begin
                reads_next      = sat_inc(reads_reg);
                read_seen_next  = 1'b1;
                line_start_next = 1'b0;
            end
            else
            begin
                prog_next = prog_reg + 4'd1;
            end
        end
        else
        begin
            if (line_start_reg)
            begin
                if (item.data == CH_F)
                begin
                    prog_next = PROG_F;
                end
                else if (in_header_reg)
                begin
                    if (item.data == CH_S && !read_seen_reg)
                    begin
                        prog_next = PROG_S;
                    end
                    else if (is_lf)
                    begin
                        in_header_next = 1'b0;
                    end
                end
            end
            line_start_next = is_lf;
        end
    end

    assign counts.msgs  = msgs_next;
    assign counts.reads = reads_next;

    // State update; end of file returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            in_header_reg  <= 1'b1;
            read_seen_reg  <= 1'b0;
            prog_reg       <= PROG_IDLE;
            msgs_reg       <= '0;
            reads_reg      <= '0;
        end
        else if (proc_en)
        begin
            if (item.eof)
            begin
                line_start_reg <= 1'b1;
                in_header_reg  <= 1'b1;
                read_seen_reg  <= 1'b0;
                prog_reg       <= PROG_IDLE;
                msgs_reg       <= '0;
                reads_reg      <= '0;
            end
            else
            begin
                line_start_reg <= line_start_next;
                in_header_reg  <= in_header_next;
                read_seen_reg  <= read_seen_next;
                prog_reg       <= prog_next;
                msgs_reg       <= msgs_next;
                reads_reg      <= reads_next;
            end
        end
    end

endmodule

/* src/mmc_out_stage.sv */
module mmc_out_stage
    import mmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  count_pair_t       counts,
    input  logic              out_stall,
    output logic              out_free,
    output logic              out_valid,
    output logic [OUT_W-1:0]  message_count,
    output logic [OUT_W-1:0]  unread_count
);

    logic        vld_reg;
    logic        vld_next;
    count_pair_t counts_reg;
    logic [COUNT_WIDTH-1:0] diff;

    assign out_free = !vld_reg || !out_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (vld_reg && !out_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            counts_reg <= counts;
        end
    end

    // Unread = messages - reads, floored at zero, then clamped to field width
    assign diff = (counts_reg.msgs > counts_reg.reads) ?
                  (counts_reg.msgs - counts_reg.reads) : '0;

    assign out_valid     = vld_reg;
    assign message_count = clamp_out(counts_reg.msgs);
    assign unread_count  = clamp_out(diff);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import mmc_pkg::*;

    // cycles without any transaction before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    // result register depth plus margin
    localparam int DRAIN_CYCLES = 8;

    typedef enum int
    {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH
    } idle_phase_t;

    typedef enum int
    {
        LN_FROM,
        LN_STATUS_READ,
        LN_STATUS_OTHER,
        LN_BROKEN,
        LN_BLANK,
        LN_NOISE,
        LN_LETTERS,
        LN_QUOTED_FROM
    } line_kind_t;

    typedef struct
    {
        logic [OUT_W-1:0] messages;
        logic [OUT_W-1:0] unread;
    } mbox_counts_t;

    // Tracks the mailbox scan and holds the counts each end of file must produce
    class count_scoreboard;
        bit                     line_start;
        bit                     header;
        bit                     read_done;
        logic [3:0]             progress;
        logic [COUNT_WIDTH-1:0] msgs;
        logic [COUNT_WIDTH-1:0] reads;
        logic [7:0]             from_rest[4];
        logic [7:0]             status_rest[8];
        mbox_counts_t           expected_counts[$];
        int                     errors;

        function new();
            from_rest   = '{CH_LO_R, CH_LO_O, CH_LO_M, CH_SP};
            status_rest = '{CH_LO_T, CH_LO_A, CH_LO_T, CH_LO_U,
                            CH_LO_S, CH_COLON, CH_SP, CH_R};
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            line_start = 1'b1;
            header     = 1'b1;
            read_done  = 1'b0;
            progress   = PROG_IDLE;
            msgs       = '0;
            reads      = '0;
        endfunction

        function logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function logic [OUT_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
            logic [63:0] wide;
            wide = 64'(v);
            return (wide > 64'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : wide[OUT_W-1:0];
        endfunction

        // One accepted byte transaction
        function void note_byte(input logic [7:0] b, input logic eof);
            mbox_counts_t c;
            if (progress >= PROG_F && progress <= PROG_FROM)
            begin
                if (b == from_rest[progress - PROG_F])
                begin
                    if (progress == PROG_FROM)
                    begin
                        msgs       = bump(msgs);
                        header     = 1'b1;
                        read_done  = 1'b0;
                        progress   = PROG_IDLE;
                        line_start = 1'b0;
                    end
                    else
                        progress = progress + 1'b1;
                end
                else
                begin
                    // broken match: byte only feeds the line-start flag
                    progress   = PROG_IDLE;
                    line_start = (b == CH_LF);
                end
            end
            else if (progress >= PROG_S && progress <= PROG_STATUS_SP)
            begin
                if (b == status_rest[progress - PROG_S])
                begin
                    if (progress == PROG_STATUS_SP)
                    begin
                        reads      = bump(reads);
                        read_done  = 1'b1;
                        progress   = PROG_IDLE;
                        line_start = 1'b0;
                    end
                    else
                        progress = progress + 1'b1;
                end
                else
                begin
                    progress   = PROG_IDLE;
                    line_start = (b == CH_LF);
                end
            end
            else
            begin
                progress = PROG_IDLE;
                if (line_start)
                begin
                    if (b == CH_F)
                        progress = PROG_F;
                    else if (header)
                    begin
                        if (b == CH_S && !read_done)
                            progress = PROG_S;
                        else if (b == CH_LF)
                            header = 1'b0;
                    end
                end
                line_start = (b == CH_LF);
            end

            // counts leave on the last byte; any partial match is dropped
            if (eof)
            begin
                c.messages = to_field(msgs);
                c.unread   = to_field((msgs > reads) ? msgs - reads : '0);
                expected_counts.push_back(c);
                clear_scan();
            end
        endfunction

        // One accepted result transaction
        function void check_result(input logic [OUT_W-1:0] mc, input logic [OUT_W-1:0] uc);
            mbox_counts_t c;
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected result message_count=%0d unread_count=%0d",
                         $time, mc, uc);
                errors++;
                return;
            end
            c = expected_counts.pop_front();
            if (mc !== c.messages)
            begin
                $display("%0t: message_count mismatch: expected %0d actual %0d",
                         $time, c.messages, mc);
                errors++;
            end
            if (uc !== c.unread)
            begin
                $display("%0t: unread_count mismatch: expected %0d actual %0d",
                         $time, c.unread, uc);
                errors++;
            end
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic [7:0]       data_byte   = 8'h00;
    logic             end_of_file = 1'b0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [OUT_W-1:0] message_count;
    logic [OUT_W-1:0] unread_count;

    count_scoreboard sb = new();
    idle_phase_t     phase = PH_STEADY;
    logic [7:0]      file_buf[$];
    int              bytes_sent = 0;
    int              files_sent = 0;
    int              quiet_cycles = 0;

    mbox_message_counter_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .message_count (message_count),
        .unread_count  (unread_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int sender_gap_pct(input idle_phase_t p);
        case (p)
            PH_SENDER_GAPS: return 59;
            PH_BOTH:        return 35;
            default:        return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input idle_phase_t p);
        case (p)
            PH_RECEIVER_STALLS: return 59;
            PH_BOTH:            return 35;
            default:            return 0;
        endcase
    endfunction

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= roll(receiver_stall_pct(phase));

    // Result checking and hang watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(message_count, unread_count);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (roll(sender_gap_pct(phase)))
        begin
            in_valid    <= 1'b0;
            data_byte   <= 8'($urandom);
            end_of_file <= 1'($urandom);
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, eof);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        foreach (file_buf[i])
            send_byte(file_buf[i], i == file_buf.size() - 1);
        files_sent++;
        file_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_buf.push_back(s[i]);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            file_buf.push_back(8'($urandom_range(255)));
    endtask

    // Random mailbox: From and Status lines, broken ones, blank, noise, letters, quoted From
    task automatic make_file();
        line_kind_t kind;
        string      pat;
        logic [7:0] letters[8];
        int         cut;
        letters = '{CH_F, CH_S, CH_LO_R, CH_LO_O, CH_LO_M, CH_SP, CH_LF, CH_LO_T};
        repeat ($urandom_range(1, 3))
        begin
            kind = line_kind_t'($urandom_range(0, 7));
            case (kind)
                LN_FROM:
                begin
                    put_text("From ");
                    put_noise($urandom_range(0, 2));
                    file_buf.push_back(CH_LF);
                end
                LN_STATUS_READ:
                begin
                    put_text("Status: R");
                    if ($urandom_range(1))
                        put_text("O");
                    file_buf.push_back(CH_LF);
                end
                LN_STATUS_OTHER:
                begin
                    put_text("Status: ");
                    put_noise(1);
                    file_buf.push_back(CH_LF);
                end
                LN_BROKEN:
                begin
                    pat = $urandom_range(1) ? "From " : "Status: R";
                    put_text(pat.substr(0, $urandom_range(0, pat.len() - 2)));
                    if ($urandom_range(1))
                        file_buf.push_back(CH_LF);
                    else
                        put_noise(1);
                end
                LN_BLANK:
                    file_buf.push_back(CH_LF);
                LN_NOISE:
                begin
                    put_noise($urandom_range(1, 3));
                    file_buf.push_back(CH_LF);
                end
                LN_LETTERS:
                    repeat ($urandom_range(1, 4))
                        file_buf.push_back(letters[$urandom_range(0, 7)]);
                default:
                    put_text("> From \n");
            endcase
        end
        // sometimes end the file in the middle of a line
        if ($urandom_range(3) == 0)
        begin
            cut = $urandom_range(0, file_buf.size() - 1);
            file_buf = file_buf[0:cut];
        end
    endtask

    initial
    begin
        int phase_bytes;
        int phase_files;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: byte extremes, status before any From, partial matches at end
        file_buf.push_back(8'h00);
        send_file();
        file_buf.push_back(8'hFF);
        send_file();
        put_text("Status: R\n");
        send_file();
        put_text("From ");
        send_file();
        put_text("Fro");
        send_file();
        put_text("Stat");
        send_file();

        // Random files through each idling phase
        for (int p = PH_STEADY; p <= PH_BOTH; p++)
        begin
            phase = idle_phase_t'(p);
            phase_bytes = bytes_sent;
            phase_files = files_sent;
            while (bytes_sent - phase_bytes < 100 || files_sent - phase_files < 10)
            begin
                make_file();
                send_file();
            end
        end

        in_valid <= 1'b0;
        phase = PH_STEADY;
        while (sb.expected_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
